// File: rtl/core/tnsi_pkg.sv
// ----------------------------------------------------------------------------
// tnsi_pkg
// Shared types and constants of the top-N sorted insert block.
// ----------------------------------------------------------------------------
package tnsi_pkg;

    // Default number of entries the list can hold
    localparam int MAX_ENTRIES_DEF = 64;

    // Fixed field widths
    localparam int OPCODE_W = 2;
    localparam int ID_W     = 20;
    localparam int SCORE_W  = 16;
    localparam int VOTES_W  = 32;
    localparam int RIDX_W   = 6;
    localparam int SLOT_W   = 6;
    localparam int FILL_W   = 7;
    localparam int CAP_W    = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Packed stream widths
    localparam int S_TDATA_W = 80;  // 75 bits of fields, padded to bytes
    localparam int M_TDATA_W = 56;  // 51 bits of fields, padded to bytes

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_OFFER = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PROBE,
        ST_CMP,
        ST_PLACE,
        ST_SHIFT,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the accepted item
        logic clear;   // empty the list
        logic fetch;   // read the entry at read_index
        logic init;    // trim to capacity and start the search
        logic probe;   // read the entry at the search midpoint
        logic step;    // narrow the search from the probed entry
        logic place;   // grow the list and set up the shift
        logic shift;   // move entries one position down
        logic write;   // store the new record at its slot
        logic emit;    // load the result register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic offer_ok;     // flag set, enough votes, capacity above zero
        logic search_more;  // search window not empty
        logic found;        // probed score equals the offered one
        logic place_ok;     // slot below capacity
        logic shift_more;   // entries still to move
        logic out_free;     // result register can take a new result
    } status_t;

endpackage

// File: rtl/core/tnsi_ram.sv
// ----------------------------------------------------------------------------
// tnsi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tnsi_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tnsi_dp.sv
// ----------------------------------------------------------------------------
// tnsi_dp
// Datapath: item capture, configuration, list store, search window, shift
// pointers and the result register.
// ----------------------------------------------------------------------------
module tnsi_dp #(
    parameter int MAX_ENTRIES = tnsi_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item
    input  logic [tnsi_pkg::OPCODE_W-1:0]      in_opcode,
    input  logic [tnsi_pkg::ID_W-1:0]          in_record_id,
    input  logic [tnsi_pkg::SCORE_W-1:0]       in_score,
    input  logic [tnsi_pkg::VOTES_W-1:0]       in_votes,
    input  logic                               in_genre_match,
    input  logic [tnsi_pkg::RIDX_W-1:0]        in_read_index,
    // configuration
    input  logic                               cfg_we,
    input  logic [tnsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tnsi_pkg::CFG_W-1:0]         cfg_data,
    // controller
    input  tnsi_pkg::cmd_t                     cmd,
    output tnsi_pkg::status_t                  st,
    // result
    input  logic                               m_tready,
    output logic                               out_valid,
    output logic                               out_inserted,
    output logic [tnsi_pkg::SLOT_W-1:0]        out_slot,
    output logic [tnsi_pkg::FILL_W-1:0]        out_fill,
    output logic [tnsi_pkg::ID_W-1:0]          out_entry_id,
    output logic [tnsi_pkg::SCORE_W-1:0]       out_entry_score,
    output logic                               out_entry_valid
);

    import tnsi_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WW     = (CNT_W > 7) ? CNT_W : 7;
    localparam int WORD_W = ID_W + SCORE_W;

    // Captured item
    op_t                op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               elig_reg;
    logic [RIDX_W-1:0]  ridx_reg;

    // Configuration
    logic [CAP_W-1:0]   cap_reg;
    logic [VOTES_W-1:0] min_count_reg;

    // List control
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] sh_reg, sh_next;
    logic [IDX_W-1:0] wa_reg, wa_next;
    logic             wpend_reg, wpend_next;

    // Result
    logic               out_valid_reg;
    logic               ins_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               out_ins_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [FILL_W-1:0]  out_fill_reg;
    logic [ID_W-1:0]    out_eid_reg;
    logic [SCORE_W-1:0] out_esc_reg;
    logic               out_evalid_reg;

    // RAM ports
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [SCORE_W-1:0] rd_score;

    // Derived values
    logic [WW-1:0]    cap_w, eff_w, held_w, lo_w, ridx_w;
    logic [CNT_W-1:0] eff_cap, trimmed, grown, mid;
    logic             rd_valid;

    tnsi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id    = ram_rdata[ID_W-1:0];
    assign rd_score = ram_rdata[WORD_W-1:ID_W];

    // Capacity clipped to the store depth
    assign cap_w   = WW'(cap_reg);
    assign eff_w   = (cap_w > WW'(MAX_ENTRIES)) ? WW'(MAX_ENTRIES) : cap_w;
    assign eff_cap = eff_w[CNT_W-1:0];
    assign trimmed = (held_reg > eff_cap) ? eff_cap : held_reg;
    assign grown   = (held_reg < eff_cap) ? held_reg + CNT_W'(1) : held_reg;
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign held_w   = WW'(held_reg);
    assign lo_w     = WW'(lo_reg);
    assign ridx_w   = WW'(ridx_reg);
    assign rd_valid = (op_reg == OP_READ) && (ridx_w < held_w)
                      && (ridx_w < WW'(MAX_ENTRIES));

    // Status to controller
    always_comb
    begin
        st.op          = op_reg;
        st.offer_ok    = (eff_cap != '0) && elig_reg;
        st.search_more = lo_reg < hi_reg;
        st.found       = rd_score == score_reg;
        st.place_ok    = lo_reg < eff_cap;
        st.shift_more  = CNT_W'(sh_reg) > lo_reg;
        st.out_free    = !out_valid_reg || m_tready;
    end

    // RAM read address and enable
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        priority if (cmd.fetch)
        begin
            ram_re    = 1'b1;
            ram_raddr = ridx_w[IDX_W-1:0];
        end
        else if (cmd.probe)
        begin
            ram_re    = 1'b1;
            ram_raddr = mid[IDX_W-1:0];
        end
        else if (cmd.shift && st.shift_more)
        begin
            ram_re    = 1'b1;
            ram_raddr = sh_reg - IDX_W'(1);
        end
    end

    // RAM write: a moved entry or the new record
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        priority if (cmd.shift && wpend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wa_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.write)
        begin
            ram_we    = 1'b1;
            ram_waddr = lo_reg[IDX_W-1:0];
            ram_wdata = {score_reg, id_reg};
        end
    end

    // Next values of list control
    always_comb
    begin
        held_next  = held_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        sh_next    = sh_reg;
        wa_next    = wa_reg;
        wpend_next = wpend_reg;
        if (cmd.clear)
        begin
            held_next = '0;
        end
        if (cmd.init)
        begin
            held_next = trimmed;
            lo_next   = '0;
            hi_next   = trimmed;
        end
        if (cmd.step)
        begin
            priority if (rd_score > score_reg)
            begin
                lo_next = mid + CNT_W'(1);
            end
            else if (rd_score < score_reg)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid;
            end
        end
        if (cmd.place)
        begin
            held_next  = grown;
            sh_next    = IDX_W'(grown - CNT_W'(1));
            wpend_next = 1'b0;
        end
        if (cmd.shift)
        begin
            if (st.shift_more)
            begin
                wa_next    = sh_reg;
                sh_next    = sh_reg - IDX_W'(1);
                wpend_next = 1'b1;
            end
            else
            begin
                wpend_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            min_count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            wpend_reg <= wpend_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPACITY)
                begin
                    cap_reg <= cfg_data[CAP_W-1:0];
                end
                else
                begin
                    min_count_reg <= cfg_data;
                end
            end
        end
    end

    // Item capture, shift pointers and result payload
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        wa_reg <= wa_next;
        if (cmd.load)
        begin
            op_reg    <= op_t'(in_opcode);
            id_reg    <= in_record_id;
            score_reg <= in_score;
            elig_reg  <= in_genre_match && (in_votes >= min_count_reg);
            ridx_reg  <= in_read_index;
            ins_reg   <= 1'b0;
            slot_reg  <= '0;
        end
        if (cmd.write)
        begin
            ins_reg  <= 1'b1;
            slot_reg <= lo_w[SLOT_W-1:0];
        end
        if (cmd.emit)
        begin
            out_ins_reg    <= ins_reg;
            out_slot_reg   <= slot_reg;
            out_fill_reg   <= held_w[FILL_W-1:0];
            out_eid_reg    <= rd_valid ? rd_id : '0;
            out_esc_reg    <= rd_valid ? rd_score : '0;
            out_evalid_reg <= rd_valid;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_inserted    = out_ins_reg;
    assign out_slot        = out_slot_reg;
    assign out_fill        = out_fill_reg;
    assign out_entry_id    = out_eid_reg;
    assign out_entry_score = out_esc_reg;
    assign out_entry_valid = out_evalid_reg;

`ifndef SYNTHESIS
    // Search window never inverts
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    // A moved entry never lands on the insert slot
    a_shift_target: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && wpend_reg) |-> (CNT_W'(wa_reg) > lo_reg))
        else $error("shift writes at or above the slot");

    // Fill count stays within the store
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond store depth");

    // A new result never overwrites one still waiting
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");
`endif

endmodule

// File: rtl/core/tnsi_ctrl.sv
// ----------------------------------------------------------------------------
// tnsi_ctrl
// Controller: sequences decode, binary search, shift, write and result load.
// ----------------------------------------------------------------------------
module tnsi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tnsi_pkg::status_t st,
    output tnsi_pkg::cmd_t    cmd
);

    import tnsi_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (st.op == OP_OFFER && st.offer_ok)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PROBE:
            begin
                state_next = st.search_more ? ST_CMP : ST_PLACE;
            end
            ST_CMP:
            begin
                state_next = st.found ? ST_PLACE : ST_PROBE;
            end
            ST_PLACE:
            begin
                state_next = st.place_ok ? ST_SHIFT : ST_FINISH;
            end
            ST_SHIFT:
            begin
                if (!st.shift_more)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                unique case (st.op)
                    OP_CLEAR: cmd.clear = 1'b1;
                    OP_OFFER: cmd.init  = 1'b1;
                    OP_READ:  cmd.fetch = 1'b1;
                    OP_NOP:   cmd.clear = 1'b0;
                endcase
            end
            ST_PROBE:  cmd.probe = st.search_more;
            ST_CMP:    cmd.step  = 1'b1;
            ST_PLACE:  cmd.place = st.place_ok;
            ST_SHIFT:  cmd.shift = 1'b1;
            ST_WRITE:  cmd.write = 1'b1;
            ST_FINISH: cmd.emit  = st.out_free;
        endcase
    end

endmodule

// File: rtl/core/top_n_sorted_insert.sv
// ----------------------------------------------------------------------------
// top_n_sorted_insert
// Keeps the best N records in descending score order by sorted insert.
// ----------------------------------------------------------------------------
//   Items enter on the s_ channel; s_tuser carries the opcode (clear, offer,
//   read, no-op) and s_tdata the record fields. Every item gives exactly one
//   result on the m_ channel. Configuration (capacity, minimum votes) is
//   written through cfg_we/cfg_index/cfg_data; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
//   One item is worked on at a time. Clear, no-op, read and an offer turned
//   away by flag, votes or zero capacity go from decode straight to the
//   result load. An accepted offer binary-searches the list, a probe being a
//   RAM read and a compare, with at most ceil(log2(fill + 1)) probes; if the
//   slot is below capacity, the entries from the slot to the list end move
//   one position down and the record is written at its slot. The next item is
//   taken as soon as its predecessor's result is in the output register.
//   Reset (rst_n low, asynchronous) empties the list and loads capacity 10
//   and minimum votes 0. A stalled receiver holds the result; a finished item
//   waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module top_n_sorted_insert #(
    parameter int MAX_ENTRIES = tnsi_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: record_id, score, votes, genre_match, read_index, zero pad
    input  logic [tnsi_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: opcode
    input  logic [tnsi_pkg::OPCODE_W-1:0]       s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: inserted, slot, fill, entry_id, entry_score, entry_valid, zero pad
    output logic [tnsi_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  logic                                cfg_we,
    input  logic [tnsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tnsi_pkg::CFG_W-1:0]          cfg_data
);

    import tnsi_pkg::*;

    cmd_t    cmd;
    status_t st;

    logic               out_inserted;
    logic [SLOT_W-1:0]  out_slot;
    logic [FILL_W-1:0]  out_fill;
    logic [ID_W-1:0]    out_entry_id;
    logic [SCORE_W-1:0] out_entry_score;
    logic               out_entry_valid;

    tnsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tnsi_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_opcode       (s_tuser),
        .in_record_id    (s_tdata[19:0]),
        .in_score        (s_tdata[35:20]),
        .in_votes        (s_tdata[67:36]),
        .in_genre_match  (s_tdata[68]),
        .in_read_index   (s_tdata[74:69]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .st              (st),
        .m_tready        (m_tready),
        .out_valid       (m_tvalid),
        .out_inserted    (out_inserted),
        .out_slot        (out_slot),
        .out_fill        (out_fill),
        .out_entry_id    (out_entry_id),
        .out_entry_score (out_entry_score),
        .out_entry_valid (out_entry_valid)
    );

    // Pack the result fields, lowest first
    assign m_tdata = {5'b0, out_entry_valid, out_entry_score, out_entry_id,
                      out_fill, out_slot, out_inserted};

endmodule

// File: sim/tb_top_n_sorted_insert.sv
// ----------------------------------------------------------------------------
// tb_top_n_sorted_insert
// Self-checking testbench of the top-N sorted insert block.
// ----------------------------------------------------------------------------
// The stimulus starts with a short directed run: every opcode, the field
// extremes, equal scores, overflow of a full list, out-of-range reads,
// zero capacity and a capacity cut below the fill. Random phases follow,
// each under its own capacity and minimum-votes setting. Setting changes
// happen only once the block has drained.
// The testbench keeps its own copy of the list and updates it on every
// accepted transfer. Each result transfer is checked field by field
// against the oldest prediction. Both sides idle in random bursts, except
// in the last phase.
// ----------------------------------------------------------------------------
module tb_top_n_sorted_insert;

    timeunit 1ns;
    timeprecision 1ps;

    import tnsi_pkg::*;

    localparam int LIST_DEPTH = MAX_ENTRIES_DEF;

    // One input item and one result, at the block's field widths
    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    rid;
        logic [SCORE_W-1:0] sc;
        logic [VOTES_W-1:0] vt;
        logic               gm;
        logic [RIDX_W-1:0]  ridx;
    } rec_item_t;

    typedef struct packed {
        logic               ins;
        logic [SLOT_W-1:0]  slot;
        logic [FILL_W-1:0]  fill;
        logic [ID_W-1:0]    eid;
        logic [SCORE_W-1:0] esc;
        logic               ev;
    } list_resp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [OPCODE_W-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Predicted list state and configuration
    logic [ID_W-1:0]        list_ids [LIST_DEPTH];
    logic [SCORE_W-1:0]     list_scores [LIST_DEPTH];
    int                     list_fill = 0;
    logic [CAP_W-1:0]       cap_cfg = CAP_RESET;
    logic [VOTES_W-1:0]     min_votes_cfg = '0;

    rec_item_t              pend_items [$];
    list_resp_t             pred_results [$];
    bit                     in_taken = 1'b0;
    bit                     quiet = 1'b0;
    int                     src_gap = 0;
    int                     sink_gap = 0;
    int                     err_cnt = 0;

    top_n_sorted_insert u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Print one mismatch line and count it
    task automatic report(string msg);
        err_cnt++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Apply one item to the predicted list, return the expected result
    function automatic list_resp_t list_model_step(rec_item_t it);
        list_resp_t r;
        int         cap;
        int         lo;
        int         hi;
        int         mid;
        r = '0;
        case (it.op)
            OP_CLEAR:
                list_fill = 0;
            OP_OFFER:
            begin
                cap = (cap_cfg > LIST_DEPTH) ? LIST_DEPTH : cap_cfg;
                // capacity cut below the fill takes effect here
                if (list_fill > cap)
                    list_fill = cap;
                if (cap > 0 && it.gm && it.vt >= min_votes_cfg)
                begin
                    // descending list: higher stored score sends search down the list
                    lo = 0;
                    hi = list_fill;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (list_scores[mid] > it.sc)
                            lo = mid + 1;
                        else if (list_scores[mid] < it.sc)
                            hi = mid;
                        else
                        begin
                            lo = mid;
                            break;
                        end
                    end
                    if (lo < cap)
                    begin
                        if (list_fill < cap)
                            list_fill++;
                        for (int i = list_fill - 1; i > lo; i--)
                        begin
                            list_ids[i]    = list_ids[i-1];
                            list_scores[i] = list_scores[i-1];
                        end
                        list_ids[lo]    = it.rid;
                        list_scores[lo] = it.sc;
                        r.ins  = 1'b1;
                        r.slot = lo[SLOT_W-1:0];
                    end
                end
            end
            OP_READ:
                if (it.ridx < list_fill)
                begin
                    r.eid = list_ids[it.ridx];
                    r.esc = list_scores[it.ridx];
                    r.ev  = 1'b1;
                end
            default: ;
        endcase
        r.fill = list_fill[FILL_W-1:0];
        return r;
    endfunction

    function automatic rec_item_t rec(op_t op, logic [ID_W-1:0] rid, logic [SCORE_W-1:0] sc,
                                      logic [VOTES_W-1:0] vt, logic gm,
                                      logic [RIDX_W-1:0] ridx);
        rec_item_t it;
        it.op   = op;
        it.rid  = rid;
        it.sc   = sc;
        it.vt   = vt;
        it.gm   = gm;
        it.ridx = ridx;
        return it;
    endfunction

    // Input driver: holds an item until its transfer, idles in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
                ;
            else if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                src_gap = $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end
            else if (pend_items.size() > 0)
            begin
                rec_item_t it;
                it = pend_items.pop_front();
                s_tdata  <= {5'b0, it.ridx, it.gm, it.vt, it.sc, it.rid};
                s_tuser  <= it.op;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: stalls in bursts
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: config writes, result checks, predictions on input transfers
    always @(posedge clk)
    begin
        list_resp_t want;
        rec_item_t  it;
        in_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CAPACITY)
                    cap_cfg = cfg_data[CAP_W-1:0];
                else
                    min_votes_cfg = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (pred_results.size() == 0)
                    report($sformatf("result 0x%0h with nothing expected", m_tdata));
                else
                begin
                    want = pred_results.pop_front();
                    check_field("inserted",    m_tdata[0],     want.ins);
                    check_field("slot",        m_tdata[6:1],   want.slot);
                    check_field("fill",        m_tdata[13:7],  want.fill);
                    check_field("entry_id",    m_tdata[33:14], want.eid);
                    check_field("entry_score", m_tdata[49:34], want.esc);
                    check_field("entry_valid", m_tdata[50],    want.ev);
                end
            end
            if (in_taken)
            begin
                it.op   = op_t'(s_tuser);
                it.rid  = s_tdata[19:0];
                it.sc   = s_tdata[35:20];
                it.vt   = s_tdata[67:36];
                it.gm   = s_tdata[68];
                it.ridx = s_tdata[74:69];
                pred_results.push_back(list_model_step(it));
            end
        end
    end

    // Wait until every item is sent and every result has come back
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pend_items.size() != 0 || s_tvalid || pred_results.size() != 0);
        repeat (4) @(posedge clk);
        #1;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain, then load a new capacity and minimum votes
    task automatic new_setting(int cap, logic [VOTES_W-1:0] minv);
        wait_drained();
        cfg_write(CFG_CAPACITY, CFG_W'(cap));
        cfg_write(CFG_MIN_COUNT, minv);
        @(posedge clk);
        #1;
    endtask

    // Random phase settings: capacity and minimum votes
    int                 plan_cap [9] = '{64, 1, 10, 0, 64, 37, 100, 64, 5};
    logic [VOTES_W-1:0] plan_min [9];

    initial
    begin
        rec_item_t it;
        int        w;
        plan_min = '{32'd0, 32'd0, $urandom, 32'd0, 32'h8000_0000, $urandom_range(0, 1000),
                     32'd0, 32'hFFFF_FFFF, 32'd0};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        #1;

        // Directed: reset setting (capacity 10, no vote minimum)
        pend_items.push_back(rec(OP_NOP, 20'h5A5A5, 16'h1234, 32'd7, 1'b1, 6'd3));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd0));
        pend_items.push_back(rec(OP_OFFER, 20'hFFFFF, 16'h8000, 32'd0, 1'b1, 6'd0));
        // genre flag clear: rejected
        pend_items.push_back(rec(OP_OFFER, 20'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 6'd63));
        pend_items.push_back(rec(OP_OFFER, 20'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 6'd0));
        pend_items.push_back(rec(OP_OFFER, 20'd2, 16'h0000, 32'd5, 1'b1, 6'd0));
        // equal score goes in front of the stored one
        pend_items.push_back(rec(OP_OFFER, 20'd3, 16'h8000, 32'd5, 1'b1, 6'd0));
        // fill up and overflow a full list
        for (int k = 1; k <= 7; k++)
            pend_items.push_back(rec(OP_OFFER, 20'(10 + k), 16'(k * 16'h1000), 32'd9, 1'b1,
                                     6'd0));
        pend_items.push_back(rec(OP_OFFER, 20'd30, 16'h0000, 32'd9, 1'b1, 6'd0));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd0));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd9));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd10));
        pend_items.push_back(rec(OP_READ, 20'hFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 6'd63));
        pend_items.push_back(rec(OP_CLEAR, 20'd0, 16'd0, 32'd0, 1'b0, 6'd0));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd0));

        // Highest vote minimum: only the top count passes
        new_setting(64, 32'hFFFF_FFFF);
        pend_items.push_back(rec(OP_OFFER, 20'd5, 16'h1234, 32'hFFFF_FFFF, 1'b1, 6'd0));
        pend_items.push_back(rec(OP_OFFER, 20'd6, 16'h4321, 32'hFFFF_FFFE, 1'b1, 6'd0));
        for (int k = 0; k < 6; k++)
            pend_items.push_back(rec(OP_OFFER, 20'($urandom), 16'($urandom), 32'hFFFF_FFFF,
                                     1'b1, 6'd0));

        // Capacity cut below the fill: trimmed on the next offer
        new_setting(3, 32'd0);
        pend_items.push_back(rec(OP_OFFER, 20'd7, 16'h0100, 32'd1, 1'b0, 6'd0));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd5));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd2));

        // Zero capacity keeps nothing
        new_setting(0, 32'd0);
        pend_items.push_back(rec(OP_OFFER, 20'd8, 16'hFFFF, 32'd1, 1'b1, 6'd0));
        pend_items.push_back(rec(OP_READ, 20'd0, 16'd0, 32'd0, 1'b0, 6'd0));

        // Random phases
        for (int p = 0; p < 9; p++)
        begin
            new_setting(plan_cap[p], plan_min[p]);
            if (p == 8)
                quiet = 1'b1;
            for (int n = 0; n < 45; n++)
            begin
                w = $urandom_range(0, 99);
                if (w < 3)
                    it.op = OP_CLEAR;
                else if (w < 8)
                    it.op = OP_NOP;
                else if (w < 30)
                    it.op = OP_READ;
                else
                    it.op = OP_OFFER;
                it.rid = 20'($urandom);
                // a small score set makes equal scores common
                if ($urandom_range(0, 1) == 0)
                    it.sc = 16'($urandom_range(0, 15)) << 8;
                else
                    it.sc = 16'($urandom);
                case ($urandom_range(0, 3))
                    0: it.vt = $urandom;
                    1: it.vt = plan_min[p];
                    2: it.vt = plan_min[p] - 32'd1;
                    default: it.vt = plan_min[p] + 32'($urandom_range(0, 100));
                endcase
                it.gm = ($urandom_range(0, 99) < 85);
                if ($urandom_range(0, 1) == 0)
                    it.ridx = 6'($urandom_range(0, 63));
                else
                    it.ridx = 6'($urandom_range(0, 15));
                pend_items.push_back(it);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
